### rtl/fri_pkg.sv
// ---------------------------------------------------------------------------
// fri_pkg
// Shared widths, command codes and the table control bundle for the
// single-precision reciprocal table/interpolation block.
// ---------------------------------------------------------------------------
package fri_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SLOPE_WIDTH = 13;
   localparam int BASE_W      = 24;

   // float layout
   localparam int MANT_W    = 23;
   localparam int EXP_W     = 8;
   localparam int FRAC_BITS = 13;
   localparam int PROD_W    = FRAC_BITS + SLOPE_WIDTH;
   localparam int REXP_W    = EXP_W + 2;

   // port widths
   localparam int CMD_W     = 2;
   localparam int OPERAND_W = 32;
   localparam int VALUE_W   = 24;
   localparam int RESULT_W  = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_RECIP      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_BASE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_SLOPE = 2'd2;

   // exponent constants
   localparam logic [REXP_W-1:0] REXP_EXACT = REXP_W'(254);
   localparam logic [REXP_W-1:0] REXP_INTERP = REXP_W'(253);
   localparam logic [EXP_W-1:0]  EXP_ZERO   = '0;
   localparam logic [EXP_W-1:0]  EXP_SPECIAL = '1;

   // control bundle from the front of the pipeline to the tables
   typedef struct packed {
      logic              wr_base;
      logic              wr_slope;
      logic              rd_en;
      logic [IDX_W-1:0]  wr_idx;
      logic [IDX_W-1:0]  rd_idx;
      logic [BASE_W-1:0] wr_data;
   } lut_ctl_type;

endpackage

### rtl/fri_lut.sv
// ---------------------------------------------------------------------------
// fri_lut
// Base and slope stores: one write port each, one registered read per cycle while
// rd_en is set, shared by both stores at the same entry.
// ---------------------------------------------------------------------------
module fri_lut (
   input  logic                                clock,
   input  fri_pkg::lut_ctl_type                ctl,
   output logic [fri_pkg::BASE_W-1:0]          base_rd,
   output logic [fri_pkg::SLOPE_WIDTH-1:0]     slope_rd
);
   import fri_pkg::*;

   logic [BASE_W-1:0]      base_mem  [TABLE_DEPTH];
   logic [SLOPE_WIDTH-1:0] slope_mem [TABLE_DEPTH];
   logic [BASE_W-1:0]      base_rd_ff;
   logic [SLOPE_WIDTH-1:0] slope_rd_ff;

   // base store write
   always_ff @(posedge clock) begin
      if (ctl.wr_base) begin
         base_mem[ctl.wr_idx] <= ctl.wr_data;
      end
   end

   // slope store write, low bits only
   always_ff @(posedge clock) begin
      if (ctl.wr_slope) begin
         slope_mem[ctl.wr_idx] <= ctl.wr_data[SLOPE_WIDTH-1:0];
      end
   end

   // registered read, held while the first stage is held
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         base_rd_ff  <= base_mem[ctl.rd_idx];
         slope_rd_ff <= slope_mem[ctl.rd_idx];
      end
   end

   assign base_rd  = base_rd_ff;
   assign slope_rd = slope_rd_ff;

endmodule

### rtl/float_reciprocal_table_interp.sv
// ---------------------------------------------------------------------------
// float_reciprocal_table_interp
// Approximate single-precision reciprocal: table base minus interpolated
// slope term, with load commands that fill the two tables.
// ---------------------------------------------------------------------------
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | command, operand, table_index, table_value
// rsp     | out       | rsp_valid/rsp_stall | result, range_error
//
// One beat accepted per cycle while req_stall is low. A reciprocal passes the registered
// stages table read, 13 x SLOPE_WIDTH multiply and subtract/format before it leaves.
// Load commands write the table at acceptance and give no response beat.
// Reset (synchronous) clears the stage valid bits; the tables are not cleared.
// A stall on rsp fills the empty stages first, then holds req_stall high.
// ---------------------------------------------------------------------------
module float_reciprocal_table_interp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [fri_pkg::CMD_W-1:0]        req_command,
   input  logic [fri_pkg::OPERAND_W-1:0]    req_operand,
   input  logic [fri_pkg::IDX_W-1:0]        req_table_index,
   input  logic [fri_pkg::VALUE_W-1:0]      req_table_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [fri_pkg::RESULT_W-1:0]     rsp_result,
   output logic                             rsp_range_error
);
   import fri_pkg::*;

   // stage advance control
   logic ld3;
   logic ld2;
   logic ld1;
   logic req_accept;
   logic is_recip;
   logic is_load_base;
   logic is_load_slope;
   lut_ctl_type lut_ctl;

   // stage 1: table read
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_sign_ff;
   logic [EXP_W-1:0]     s1_bexp_ff;
   logic                 s1_mzero_ff;
   logic [FRAC_BITS-1:0] s1_low_ff;
   logic [BASE_W-1:0]    s1_base;
   logic [SLOPE_WIDTH-1:0] s1_slope;

   // stage 2: product
   logic                   s2_valid_ff, s2_valid_in;
   logic                   s2_sign_ff;
   logic [EXP_W-1:0]       s2_bexp_ff;
   logic                   s2_mzero_ff;
   logic [BASE_W-1:0]      s2_base_ff;
   logic [SLOPE_WIDTH-1:0] s2_prod_ff, s2_prod_in;
   logic [PROD_W-1:0]      mult_full;

   // stage 3: response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0] rsp_result_ff, rsp_result_in;
   logic                rsp_range_error_ff, rsp_range_error_in;
   logic [BASE_W-1:0]   diff;
   logic [MANT_W-1:0]   frac;
   logic [REXP_W-1:0]   rexp;

   // handshake: a stage loads when it is empty or its contents move on
   assign ld3        = !rsp_valid_ff || !rsp_stall;
   assign ld2        = !s2_valid_ff || ld3;
   assign ld1        = !s1_valid_ff || ld2;
   assign req_stall  = !ld1;
   assign req_accept = req_valid && ld1;

   // command decode
   always_comb begin
      is_recip      = 1'b0;
      is_load_base  = 1'b0;
      is_load_slope = 1'b0;
      unique case (req_command)
         CMD_RECIP:      is_recip      = 1'b1;
         CMD_LOAD_BASE:  is_load_base  = 1'b1;
         CMD_LOAD_SLOPE: is_load_slope = 1'b1;
         default:        ;
      endcase
   end

   // table access
   always_comb begin
      lut_ctl.wr_base  = req_accept && is_load_base;
      lut_ctl.wr_slope = req_accept && is_load_slope;
      lut_ctl.rd_en    = ld1;
      lut_ctl.wr_idx   = req_table_index;
      lut_ctl.rd_idx   = req_operand[FRAC_BITS +: IDX_W];
      lut_ctl.wr_data  = req_table_value[BASE_W-1:0];
   end

   fri_lut u_lut (
      .clock    (clock),
      .ctl      (lut_ctl),
      .base_rd  (s1_base),
      .slope_rd (s1_slope)
   );

   // stage 1 registers
   assign s1_valid_in = ld1 ? (req_accept && is_recip) : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_sign_ff  <= req_operand[OPERAND_W-1];
         s1_bexp_ff  <= req_operand[MANT_W +: EXP_W];
         s1_mzero_ff <= (req_operand[MANT_W-1:0] == '0);
         s1_low_ff   <= req_operand[FRAC_BITS-1:0];
      end
   end

   // stage 2: interpolation product
   assign mult_full   = PROD_W'(s1_low_ff) * PROD_W'(s1_slope);
   assign s2_prod_in  = mult_full[PROD_W-1:FRAC_BITS];
   assign s2_valid_in = ld2 ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld2) begin
         s2_sign_ff  <= s1_sign_ff;
         s2_bexp_ff  <= s1_bexp_ff;
         s2_mzero_ff <= s1_mzero_ff;
         s2_base_ff  <= s1_base;
         s2_prod_ff  <= s2_prod_in;
      end
   end

   // stage 3: subtract, exponent and range check
   always_comb begin
      diff = s2_base_ff - BASE_W'(s2_prod_ff);
      if (s2_mzero_ff) begin
         frac = '0;
         rexp = REXP_EXACT - REXP_W'(s2_bexp_ff);
      end else begin
         frac = {diff[MANT_W-2:0], 1'b0};
         rexp = REXP_INTERP - REXP_W'(s2_bexp_ff);
      end
      rsp_result_in      = {s2_sign_ff, rexp[EXP_W-1:0], frac};
      rsp_range_error_in = (s2_bexp_ff == EXP_ZERO) || (s2_bexp_ff == EXP_SPECIAL)
                           || rexp[REXP_W-1] || (rexp[REXP_W-2:EXP_W] != '0);
   end

   assign rsp_valid_in = ld3 ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         rsp_result_ff      <= rsp_result_in;
         rsp_range_error_ff <= rsp_range_error_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result      = rsp_result_ff;
   assign rsp_range_error = rsp_range_error_ff;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for float_reciprocal_table_interp. Loads fill a local
// copy of the base and slope tables, and each reciprocal beat is predicted
// from that copy and queued. Every response beat is compared field by field
// against the oldest queued prediction. Both channels idle at random.
// ---------------------------------------------------------------------------
module tb_top;
   import fri_pkg::*;

   // command code with no function in the block
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [RESULT_W-1:0] result;
      logic                range_error;
   } recip_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_command = CMD_RECIP;
   logic [OPERAND_W-1:0] req_operand = '0;
   logic [IDX_W-1:0]     req_table_index = '0;
   logic [VALUE_W-1:0]   req_table_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [RESULT_W-1:0]  rsp_result;
   logic                 rsp_range_error;

   // local copy of the tables and which entries hold data
   logic [BASE_W-1:0]      base_copy [TABLE_DEPTH];
   logic [SLOPE_WIDTH-1:0] slope_copy [TABLE_DEPTH];
   bit                     base_loaded [TABLE_DEPTH];
   bit                     slope_loaded [TABLE_DEPTH];
   int                     readable_keys [$];

   recip_beat_type pending_recips [$];
   int             fail_count = 0;
   int             hold_left = 0;
   bit             steady = 1'b0;

   float_reciprocal_table_interp dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_operand     (req_operand),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_range_error (rsp_range_error)
   );

   always #5 clock = ~clock;

   // reciprocal approximation from the local table copy
   function automatic recip_beat_type predict_recip(input logic [OPERAND_W-1:0] op);
      logic [IDX_W-1:0]              key;
      logic [FRAC_BITS-1:0]          low;
      logic [PROD_W-1:0]             prod;
      logic [BASE_W-1:0]             diff;
      logic [MANT_W-1:0]             frac;
      logic [EXP_W-1:0]              bexp;
      int                            rexp;
      recip_beat_type                r;
      key  = op[MANT_W-1 -: IDX_W];
      low  = op[FRAC_BITS-1:0];
      bexp = op[OPERAND_W-2 -: EXP_W];
      prod = PROD_W'(low) * PROD_W'(slope_copy[key]);
      // difference wraps when the slope term exceeds the base
      diff = base_copy[key] - BASE_W'(prod >> FRAC_BITS);
      frac = {diff[MANT_W-2:0], 1'b0};
      if (op[MANT_W-1:0] == '0) begin
         // exact power of two
         rexp = int'(REXP_EXACT) - int'(bexp);
         frac = '0;
      end else begin
         rexp = int'(REXP_INTERP) - int'(bexp);
      end
      r.range_error = (bexp == EXP_ZERO) || (bexp == EXP_SPECIAL) || (rexp < 0) ||
                      (rexp > int'(EXP_SPECIAL));
      r.result = {op[OPERAND_W-1], rexp[EXP_W-1:0], frac};
      return r;
   endfunction

   // one beat on the request side; the copy is updated at acceptance
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [OPERAND_W-1:0] op,
                            input logic [IDX_W-1:0] idx, input logic [VALUE_W-1:0] val);
      bit was_readable;
      while (!steady && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_command     <= cmd;
      req_operand     <= op;
      req_table_index <= idx;
      req_table_value <= val;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      was_readable = base_loaded[idx] && slope_loaded[idx];
      case (cmd)
         CMD_LOAD_BASE: begin
            base_copy[idx]   = val[BASE_W-1:0];
            base_loaded[idx] = 1'b1;
         end
         CMD_LOAD_SLOPE: begin
            slope_copy[idx]   = val[SLOPE_WIDTH-1:0];
            slope_loaded[idx] = 1'b1;
         end
         CMD_RECIP: pending_recips.push_back(predict_recip(op));
         default: ;
      endcase
      if (!was_readable && base_loaded[idx] && slope_loaded[idx])
         readable_keys.push_back(int'(idx));
   endtask

   // request side goes quiet until every reciprocal has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_recips.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] rand_table_value();
      case ($urandom_range(0, 9))
         0, 1:    return VALUE_W'($urandom_range(0, 8191));
         2:       return '1;
         3:       return '0;
         default: return VALUE_W'($urandom());
      endcase
   endfunction

   // operand whose table entry is known to be loaded
   function automatic logic [OPERAND_W-1:0] rand_operand(input logic [IDX_W-1:0] key);
      logic [EXP_W-1:0]     bexp;
      logic [FRAC_BITS-1:0] low;
      logic [IDX_W-1:0]     k;
      k = key;
      case ($urandom_range(0, 9))
         0:       bexp = EXP_ZERO;
         1:       bexp = EXP_SPECIAL;
         2:       bexp = EXP_W'($urandom_range(252, 254));
         3:       bexp = EXP_W'($urandom_range(1, 2));
         default: bexp = EXP_W'($urandom());
      endcase
      case ($urandom_range(0, 11))
         0: begin
            // zero mantissa, entry zero is always loaded
            k   = '0;
            low = '0;
         end
         1:       low = '0;
         2:       low = '1;
         default: low = FRAC_BITS'($urandom());
      endcase
      return {1'($urandom()), bexp, k, low};
   endfunction

   task automatic rand_item();
      int               pick;
      logic [IDX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      idx  = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
      if (pick < 20) begin
         // load an entry pair, then read it straight away
         send_beat(CMD_LOAD_BASE, $urandom(), idx, rand_table_value());
         send_beat(CMD_LOAD_SLOPE, $urandom(), idx, rand_table_value());
         repeat ($urandom_range(1, 3))
            send_beat(CMD_RECIP, rand_operand(idx), IDX_W'($urandom()), VALUE_W'($urandom()));
      end else if (pick < 25) begin
         send_beat(pick < 23 ? CMD_LOAD_BASE : CMD_LOAD_SLOPE, $urandom(), idx,
                   rand_table_value());
      end else if (pick < 29) begin
         send_beat(CMD_UNUSED, $urandom(), idx, VALUE_W'($urandom()));
      end else begin
         idx = IDX_W'(readable_keys[$urandom_range(0, readable_keys.size() - 1)]);
         send_beat(CMD_RECIP, rand_operand(idx), IDX_W'($urandom()), VALUE_W'($urandom()));
      end
   endtask

   // corner operands over three hand-loaded entries
   task automatic test_corners();
      logic [OPERAND_W-1:0] corner_ops [12];
      corner_ops = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'h7FFF_FFFF,
                     32'h0000_1FFF, 32'h3F80_0000, 32'h7F7F_FFFF, 32'h7F00_0000,
                     32'h0080_0000, 32'h3FFF_FFFF, 32'hBF80_1FFF, 32'hC040_0000};
      send_beat(CMD_LOAD_BASE, $urandom(), 10'd0, 24'hFF_FFFF);
      send_beat(CMD_LOAD_SLOPE, $urandom(), 10'd0, 24'h00_1FFF);
      // small base and full slope give a negative difference
      send_beat(CMD_LOAD_BASE, $urandom(), 10'd1023, 24'h00_0000);
      send_beat(CMD_LOAD_SLOPE, $urandom(), 10'd1023, 24'hFF_FFFF);
      send_beat(CMD_LOAD_BASE, $urandom(), 10'd512, 24'h5A_5A5A);
      send_beat(CMD_LOAD_SLOPE, $urandom(), 10'd512, 24'h00_0000);
      send_beat(CMD_RECIP, 32'h4040_1000, 10'd0, 24'h0);
      foreach (corner_ops[i])
         send_beat(CMD_RECIP, corner_ops[i], IDX_W'($urandom()), VALUE_W'($urandom()));
      send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 10'd1023, 24'hFF_FFFF);
      wait_for_results();
   endtask

   task automatic test_random_mix(input int beats);
      repeat (beats) rand_item();
      wait_for_results();
   endtask

   task automatic test_back_to_back(input int beats);
      steady = 1'b1;
      repeat (beats) rand_item();
      steady = 1'b0;
      wait_for_results();
   endtask

   // response side holds off while requests keep coming
   task automatic test_backpressure();
      logic [IDX_W-1:0] idx;
      hold_left = 150;
      repeat (48) begin
         idx = IDX_W'(readable_keys[$urandom_range(0, readable_keys.size() - 1)]);
         send_beat(CMD_RECIP, rand_operand(idx), IDX_W'($urandom()), VALUE_W'($urandom()));
      end
      wait_for_results();
   endtask

   // response side: check each beat, then pick the next stall value
   always @(posedge clock) begin : rsp_side
      recip_beat_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_recips.size() == 0) begin
            $error("unexpected response beat: rsp_result %h", rsp_result);
            fail_count++;
         end else begin
            want = pending_recips.pop_front();
            if (rsp_result !== want.result) begin
               $error("rsp_result expected %h actual %h", want.result, rsp_result);
               fail_count++;
            end
            if (rsp_range_error !== want.range_error) begin
               $error("rsp_range_error expected %b actual %b", want.range_error,
                      rsp_range_error);
               fail_count++;
            end
         end
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 21);
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_random_mix(650);
      test_backpressure();
      test_back_to_back(250);
      test_random_mix(180);
      if (fail_count == 0)
         $display("float_reciprocal_table_interp test passed");
      else
         $display("float_reciprocal_table_interp test failed");
      $finish;
   end

   // hang guard
   initial begin
      #2000000;
      $display("float_reciprocal_table_interp test failed");
      $finish;
   end

endmodule

### float_reciprocal_table_interp.f
rtl/fri_pkg.sv
rtl/fri_lut.sv
rtl/float_reciprocal_table_interp.sv
tb/sv/tb_top.sv
